// ===== rtl/htbd_pkg.sv =====
// shared types and constants for the huffman tree bit decoder
package htbd_pkg;

	localparam int IDX_W          = 9;
	localparam int SYM_W          = 8;
	localparam int BYTE_W         = 8;
	localparam int CNT_W          = 4;
	localparam int NODE_COUNT_DEF = 512;

	// index widened so that any node count up to 1024 fits in a compare
	localparam int EXT_W = IDX_W + 2;

	localparam logic [CNT_W-1:0] LUB_RESET = CNT_W'(BYTE_W);

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             leaf;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] left;
	} node_t;

	typedef struct packed {
		logic             valid;
		logic [SYM_W-1:0] symbol;
		logic             last;
	} push_t;

endpackage

// ===== rtl/huffman_tree_bit_decoder.sv =====
// top level of the huffman tree bit decoder
//
//  port group  | direction | transaction
//  ------------+-----------+------------------------------------------------
//  in_*        | in        | one node load or one compressed byte
//  out_*       | out       | one decoded symbol, last_of_run on the final one
//  cfg_*       | in        | write of last_used_bits
//
// a node load is written to the table when accepted; a data byte walks up to eight
// bits, one dependent node table read per bit, then settles the last node read and
// flags the final symbol. the input stalls while a byte is being walked; one byte
// at a time. a stalled output pauses the walk whenever a further symbol is ready.
// reset returns the walk to the root and sets last_used_bits to 8; the
// node table is not cleared and must be loaded before decoding.
module huffman_tree_bit_decoder import htbd_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [IDX_W-1:0]  node_index,
	input  logic [IDX_W-1:0]  left_child,
	input  logic [IDX_W-1:0]  right_child,
	input  logic              is_leaf,
	input  logic [SYM_W-1:0]  leaf_symbol,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              final_byte,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SYM_W-1:0]  symbol,
	output logic              last_of_run
);

	localparam int ADDR_W = $clog2(NODE_COUNT);

	logic              mem_wr_en, mem_rd_en, out_free;
	logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
	node_t             mem_wr_data, mem_rd_data;
	push_t             push;

	htbd_node_mem #(.NODE_COUNT(NODE_COUNT)) u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	htbd_walker #(.NODE_COUNT(NODE_COUNT)) u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.node_index  (node_index),
		.left_child  (left_child),
		.right_child (right_child),
		.is_leaf     (is_leaf),
		.leaf_symbol (leaf_symbol),
		.data_byte   (data_byte),
		.final_byte  (final_byte),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.push        (push),
		.out_free    (out_free)
	);

	htbd_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.symbol      (symbol),
		.last_of_run (last_of_run)
	);

endmodule

// ===== rtl/htbd_node_mem.sv =====
// node table memory, one write port and one registered read port
module htbd_node_mem import htbd_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	localparam int ADDR_W = $clog2(NODE_COUNT)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  node_t             wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output node_t             rd_data
);

	node_t mem_q [NODE_COUNT];
	node_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/htbd_walker.sv =====
// input side, bit shift register and tree walk control
module htbd_walker import htbd_pkg::*; #(
	parameter int NODE_COUNT = NODE_COUNT_DEF,
	localparam int ADDR_W = $clog2(NODE_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              action,
	input  logic [IDX_W-1:0]  node_index,
	input  logic [IDX_W-1:0]  left_child,
	input  logic [IDX_W-1:0]  right_child,
	input  logic              is_leaf,
	input  logic [SYM_W-1:0]  leaf_symbol,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic              final_byte,
	input  logic              cfg_wr_en,
	input  logic [CNT_W-1:0]  cfg_wr_data,
	output logic              mem_wr_en,
	output logic [ADDR_W-1:0] mem_wr_addr,
	output node_t             mem_wr_data,
	output logic              mem_rd_en,
	output logic [ADDR_W-1:0] mem_rd_addr,
	input  node_t             mem_rd_data,
	output push_t             push,
	input  logic              out_free
);

	function automatic logic in_range(input logic [IDX_W-1:0] idx);
		return {2'b00, idx} < EXT_W'(NODE_COUNT);
	endfunction

	function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
		logic [EXT_W-1:0] ext;
		ext = {2'b00, idx};
		return ext[ADDR_W-1:0];
	endfunction

	logic              busy_q, pend_v_q, sym_v_q, fin_q;
	logic [CNT_W-1:0]  bits_left_q, lub_q, first_bits;
	logic [BYTE_W-1:0] shift_q;
	logic [IDX_W-1:0]  pend_idx_q, cur_idx_q, eff_idx, next_idx;
	node_t             cur_entry_q, root_q, eff_entry, new_node;
	logic [SYM_W-1:0]  sym_q;
	logic              accept, load_ok, leaf_hit, push_mid, at_end, push_end;
	logic              step_ok, next_ok, issue;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign load_ok  = accept && action == ACT_LOAD && in_range(node_index);

	assign new_node = '{symbol: leaf_symbol, leaf: is_leaf, right: right_child,
		left: left_child};

	assign mem_wr_en   = load_ok;
	assign mem_wr_addr = to_addr(node_index);
	assign mem_wr_data = new_node;

	assign first_bits = final_byte ? ((lub_q > CNT_W'(BYTE_W)) ? CNT_W'(BYTE_W) : lub_q)
		: CNT_W'(BYTE_W);

	// a leaf returned by the pending node table read sends the walk back to the root
	assign leaf_hit = pend_v_q && mem_rd_data.leaf;
	assign push_mid = leaf_hit && sym_v_q;
	assign at_end   = !pend_v_q && bits_left_q == '0;
	assign push_end = at_end && sym_v_q;
	assign step_ok  = busy_q && (!(push_mid || push_end) || out_free);

	always_comb begin
		if (pend_v_q) begin
			if (mem_rd_data.leaf) begin
				eff_entry = root_q;
				eff_idx   = '0;
			end else begin
				eff_entry = mem_rd_data;
				eff_idx   = pend_idx_q;
			end
		end else begin
			eff_entry = cur_entry_q;
			eff_idx   = cur_idx_q;
		end
	end

	assign next_idx    = shift_q[0] ? eff_entry.right : eff_entry.left;
	assign next_ok     = in_range(next_idx);
	assign issue       = step_ok && bits_left_q != '0;
	assign mem_rd_en   = issue && next_ok;
	assign mem_rd_addr = to_addr(next_idx);

	// symbol is held back one leaf so the last of the byte can be flagged
	assign push.valid  = step_ok && (push_mid || push_end);
	assign push.symbol = sym_q;
	assign push.last   = push_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			sym_v_q     <= 1'b0;
			bits_left_q <= '0;
			lub_q       <= LUB_RESET;
			cur_idx_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				lub_q <= cfg_wr_data;
			end
			if (accept && action == ACT_DECODE) begin
				busy_q      <= 1'b1;
				bits_left_q <= first_bits;
			end
			if (step_ok) begin
				if (leaf_hit) begin
					sym_v_q <= 1'b1;
				end
				if (bits_left_q != '0) begin
					bits_left_q <= bits_left_q - 1'b1;
					pend_v_q    <= next_ok;
					cur_idx_q   <= next_ok ? eff_idx : '0;
				end else if (pend_v_q) begin
					pend_v_q  <= 1'b0;
					cur_idx_q <= eff_idx;
				end else begin
					sym_v_q <= 1'b0;
					busy_q  <= 1'b0;
					if (fin_q) begin
						cur_idx_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && action == ACT_DECODE) begin
			shift_q <= data_byte;
			fin_q   <= final_byte;
		end
		// keep cached copies coherent with the table
		if (load_ok) begin
			if (node_index == cur_idx_q) begin
				cur_entry_q <= new_node;
			end
			if (node_index == '0) begin
				root_q <= new_node;
			end
		end
		if (step_ok) begin
			if (leaf_hit) begin
				sym_q <= mem_rd_data.symbol;
			end
			if (bits_left_q != '0) begin
				shift_q    <= shift_q >> 1;
				pend_idx_q <= next_idx;
				cur_entry_q <= next_ok ? eff_entry : root_q;
			end else if (pend_v_q) begin
				cur_entry_q <= eff_entry;
			end else if (fin_q) begin
				cur_entry_q <= root_q;
			end
		end
	end

	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= CNT_W'(BYTE_W))
		else $error("bit count beyond a byte");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_v_q || sym_v_q) |-> busy_q)
		else $error("walk state left over while idle");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_wr_en && mem_rd_en))
		else $error("node table written during a walk");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> out_free)
		else $error("symbol pushed into a full output register");

	a_done_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && at_end && step_ok) |=> !busy_q)
		else $error("walk did not finish after the last bit");

endmodule

// ===== rtl/htbd_out_reg.sv =====
// output register holding one decoded symbol transaction
module htbd_out_reg import htbd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	output logic             out_free,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [SYM_W-1:0] symbol,
	output logic             last_of_run
);

	logic             valid_q;
	logic [SYM_W-1:0] symbol_q;
	logic             last_q;

	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push.valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			symbol_q <= push.symbol;
			last_q   <= push.last;
		end
	end

	assign out_valid   = valid_q;
	assign symbol      = symbol_q;
	assign last_of_run = last_q;

endmodule

// ===== test/huffman_tree_bit_decoder_tb.sv =====
// testbench for the huffman tree bit decoder: directed and random node loads and byte decodes
`timescale 1ns / 100ps

module huffman_tree_bit_decoder_tb;
	import htbd_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 16;
	localparam int ITEM_TARGET  = 100;

	typedef struct {
		logic              act;
		logic [IDX_W-1:0]  idx;
		logic [IDX_W-1:0]  lc;
		logic [IDX_W-1:0]  rc;
		logic              leaf;
		logic [SYM_W-1:0]  sym;
		logic [BYTE_W-1:0] data;
		logic              fin;
	} bus_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} decoded_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic              action      = ACT_LOAD;
	logic [IDX_W-1:0]  node_index  = '0;
	logic [IDX_W-1:0]  left_child  = '0;
	logic [IDX_W-1:0]  right_child = '0;
	logic              is_leaf     = 1'b0;
	logic [SYM_W-1:0]  leaf_symbol = '0;
	logic [BYTE_W-1:0] data_byte   = '0;
	logic              final_byte  = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [CNT_W-1:0]  cfg_wr_data = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [SYM_W-1:0]  symbol;
	logic              last_of_run;

	// decoder mirror
	node_t            tree_mirror [NODE_COUNT_DEF];
	logic [IDX_W-1:0] walk_node  = '0;
	logic [CNT_W-1:0] final_bits = LUB_RESET;
	decoded_t         symbols_due [$];

	// stimulus bookkeeping
	bus_item_t item_queue [$];
	bus_item_t on_bus;
	int        items_queued = 0;
	int        items_taken  = 0;
	int        send_gap     = 0;
	int        hold_out     = 0;
	bit        gaps_on      = 1'b1;
	int        mismatches   = 0;
	int        cycle_count  = 0;
	decoded_t  due;

	// nodes already given a value, so a walk never reads an unloaded entry
	bit gen_written [NODE_COUNT_DEF];
	int gen_pool [$];

	huffman_tree_bit_decoder u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic int pick_node();
		return gen_pool[$urandom_range(0, gen_pool.size() - 1)];
	endfunction

	function automatic void add_pool(input int idx);
		if (!gen_written[idx]) begin
			gen_written[idx] = 1'b1;
			gen_pool.push_back(idx);
		end
	endfunction

	// walk one accepted transaction through the mirrored tree
	task automatic walk_input(input bus_item_t it);
		node_t            here;
		node_t            kid;
		logic [IDX_W-1:0] next_idx;
		decoded_t         run [$];
		int               nbits;
		if (it.act == ACT_LOAD) begin
			tree_mirror[it.idx] = '{symbol: it.sym, leaf: it.leaf, right: it.rc, left: it.lc};
			return;
		end
		nbits = BYTE_W;
		if (it.fin && final_bits < BYTE_W)
			nbits = final_bits;
		// nine bit indices never exceed the 512 entry table, so no range check
		for (int i = 0; i < nbits; i++) begin
			here     = tree_mirror[walk_node];
			next_idx = it.data[i] ? here.right : here.left;
			kid      = tree_mirror[next_idx];
			if (kid.leaf) begin
				run.push_back('{symbol: kid.symbol, last: 1'b0});
				walk_node = '0;
			end else begin
				walk_node = next_idx;
			end
		end
		// end of stream drops any half-walked code
		if (it.fin)
			walk_node = '0;
		foreach (run[k])
			symbols_due.push_back('{symbol: run[k].symbol, last: (k == run.size() - 1)});
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				walk_input(on_bus);
				items_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0 || item_queue.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					in_valid <= 1'b0;
				end else begin
					on_bus = item_queue.pop_front();
					action      <= on_bus.act;
					node_index  <= on_bus.idx;
					left_child  <= on_bus.lc;
					right_child <= on_bus.rc;
					is_leaf     <= on_bus.leaf;
					leaf_symbol <= on_bus.sym;
					data_byte   <= on_bus.data;
					final_byte  <= on_bus.fin;
					in_valid    <= 1'b1;
					send_gap = gaps_on ? idle_len() : 0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (symbols_due.size() == 0) begin
					$error("symbol %0h arrived with none expected", symbol);
					mismatches++;
				end else begin
					due = symbols_due.pop_front();
					if (symbol !== due.symbol) begin
						$error("symbol: expected %0h, got %0h", due.symbol, symbol);
						mismatches++;
					end
					if (last_of_run !== due.last) begin
						$error("last_of_run: expected %0b, got %0b", due.last, last_of_run);
						mismatches++;
					end
				end
			end
			if (hold_out > 0) begin
				hold_out--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				hold_out = gaps_on ? idle_len() : 0;
			end
		end
	end

	task automatic push_load(input int idx, input int lc, input int rc, input bit leaf,
			input int sym);
		bus_item_t it;
		it.act  = ACT_LOAD;
		it.idx  = IDX_W'(idx);
		it.lc   = IDX_W'(lc);
		it.rc   = IDX_W'(rc);
		it.leaf = leaf;
		it.sym  = SYM_W'(sym);
		it.data = BYTE_W'($urandom);
		it.fin  = 1'($urandom);
		item_queue.push_back(it);
		items_queued++;
		add_pool(idx);
	endtask

	task automatic push_byte(input int data, input bit fin);
		bus_item_t it;
		it.act  = ACT_DECODE;
		it.idx  = IDX_W'($urandom);
		it.lc   = IDX_W'($urandom);
		it.rc   = IDX_W'($urandom);
		it.leaf = 1'($urandom);
		it.sym  = SYM_W'($urandom);
		it.data = BYTE_W'(data);
		it.fin  = fin;
		item_queue.push_back(it);
		items_queued++;
	endtask

	// random code tree from the root; now and then a branch links back to a loaded node
	task automatic build_tree(input int budget);
		int pending_nodes [$];
		bit used [NODE_COUNT_DEF];
		int kids [2];
		int n;
		int r;
		int fresh;
		add_pool(0);
		used[0] = 1'b1;
		pending_nodes.push_back(0);
		while (pending_nodes.size() != 0) begin
			n = pending_nodes.pop_front();
			for (int k = 0; k < 2; k++) begin
				r = $urandom_range(0, 99);
				if (r < 6) begin
					kids[k] = pick_node();
				end else begin
					do
						fresh = $urandom_range(1, NODE_COUNT_DEF - 1);
					while (used[fresh]);
					used[fresh] = 1'b1;
					add_pool(fresh);
					kids[k] = fresh;
					if (budget > 0 && r < 55) begin
						budget--;
						pending_nodes.push_back(fresh);
					end else begin
						push_load(fresh, pick_node(), pick_node(), 1'b1, $urandom_range(0, 255));
					end
				end
			end
			push_load(n, kids[0], kids[1], (n == 0) && ($urandom_range(0, 3) == 0),
				$urandom_range(0, 255));
		end
	endtask

	task automatic settle();
		while (items_queued != items_taken || symbols_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_final_bits(input logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		final_bits = v;
	endtask

	initial begin
		int len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// two leaves under the root: every bit yields a symbol
		push_load(0, 1, 511, 1'b0, 8'hA5);
		push_load(1, 0, 0, 1'b1, 8'h00);
		push_load(511, 511, 511, 1'b1, 8'hFF);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hA5, 1'b1);
		settle();

		// root loops on a 0 bit, so a zero byte decodes nothing; oversized bit count
		set_final_bits(4'd15);
		push_load(0, 0, 511, 1'b0, 8'h00);
		push_byte(8'h00, 1'b0);
		push_byte(8'h80, 1'b1);
		settle();

		// final byte with no bits walked
		set_final_bits(4'd0);
		push_load(3, 1, 511, 1'b0, 8'h3C);
		push_load(0, 3, 511, 1'b0, 8'h00);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h02, 1'b0);
		settle();

		// single-bit final byte ending inside a code, then a root flagged as a leaf
		set_final_bits(4'd1);
		push_byte(8'h00, 1'b1);
		push_byte(8'h01, 1'b1);
		push_byte(8'h00, 1'b0);
		push_load(0, 0, 511, 1'b1, 8'h5A);
		push_byte(8'h01, 1'b0);

		for (int ph = 0; items_queued < ITEM_TARGET; ph++) begin
			settle();
			set_final_bits((ph % 3 == 0) ? LUB_RESET : CNT_W'($urandom_range(0, 15)));
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 2)) begin
				build_tree(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
				repeat ($urandom_range(1, 3)) begin
					len = $urandom_range(1, 6);
					for (int b = 0; b < len; b++) begin
						// stray node rewrite in the middle of a stream
						if ($urandom_range(0, 9) == 0)
							push_load($urandom_range(0, NODE_COUNT_DEF - 1), pick_node(),
								pick_node(), 1'($urandom), $urandom_range(0, 255));
						push_byte($urandom_range(0, 255),
							(b == len - 1) && ($urandom_range(0, 9) != 0));
					end
				end
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
